### design/gbb_pkg.sv
// ----------------------------------------------------------------------------
// gbb_pkg
// Shared constants and types of the glyph bitmap blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package gbb_pkg;

  localparam int MAX_GLYPH_WIDTH  = 128;
  localparam int MAX_GLYPH_HEIGHT = 128;
  localparam int ROWBUF_DEPTH     = (MAX_GLYPH_WIDTH + 1) / 2;
  localparam int RB_AW            = $clog2(ROWBUF_DEPTH);
  localparam int COL_W            = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int ROW_W            = $clog2(MAX_GLYPH_HEIGHT + 1);
  localparam int PAIR_W           = 7;
  localparam int COORD_W          = 16;
  localparam int BYTE_W           = 8;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;

  localparam logic [1:0] THRESH_RST   = 2'd2;
  localparam logic [2:0] PIX_LAST_1B  = 3'd7;
  localparam logic [2:0] PIX_LAST_2B  = 3'd3;
  localparam logic [PAIR_W:0] SUM_INK_2B = (PAIR_W + 1)'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X      = 3'd0,
    CFG_ORIGIN_Y      = 3'd1,
    CFG_GLYPH_WIDTH   = 3'd2,
    CFG_GLYPH_HEIGHT  = 3'd3,
    CFG_TWO_BIT_MODE  = 3'd4,
    CFG_HALF_SCALE    = 3'd5,
    CFG_INK_THRESHOLD = 3'd6
  } gbb_cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [7:0]                glyph_width;
    logic [7:0]                glyph_height;
    logic                      two_bit_mode;
    logic                      half_scale;
    logic [1:0]                ink_threshold;
  } gbb_cfg_t;

  typedef struct packed {
    logic                      eob;
    logic                      ink;
    logic                      sum_chk;
    logic                      add_row;
    logic [PAIR_W-1:0]         pair;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } gbb_tok_t;

endpackage

`default_nettype wire

### design/gbb_in_if.sv
// ----------------------------------------------------------------------------
// gbb_in_if
// Bitmap byte channel: valid/ready handshake with byte payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] bitmap_byte;
  logic       first_byte;

  modport source (output valid, output bitmap_byte, output first_byte, input ready);
  modport sink   (input valid, input bitmap_byte, input first_byte, output ready);
endinterface

`default_nettype wire

### design/gbb_out_if.sv
// ----------------------------------------------------------------------------
// gbb_out_if
// Ink pixel channel: valid/ready handshake with screen coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic               last_of_run;

  modport source (output valid, output pixel_x, output pixel_y, output last_of_run,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

### design/gbb_ram.sv
// ----------------------------------------------------------------------------
// gbb_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/gbb_walker.sv
// ----------------------------------------------------------------------------
// gbb_walker
// Byte unpacker, pixel walker (one a cycle unless stalled), row buffer access.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_walker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gbb_pkg::gbb_cfg_t                    cfg,
  gbb_in_if.sink                               in_word,
  output logic                                 tok_valid,
  output gbb_pkg::gbb_tok_t                    tok,
  input  logic                                 tok_ready,
  output logic                                 rb_we,
  output logic [gbb_pkg::RB_AW-1:0]            rb_waddr,
  output logic [gbb_pkg::PAIR_W-1:0]           rb_wdata,
  output logic                                 rb_re,
  output logic [gbb_pkg::RB_AW-1:0]            rb_raddr
);
  import gbb_pkg::*;

  logic                a_v_r, a_v_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [PAIR_W-1:0]   pair_r, pair_nxt;
  logic                b_v_r, b_v_nxt;
  gbb_tok_t            b_tok_r, b_tok_nxt;

  logic [COL_W-1:0]    w, col0, col_s, col_inc;
  logic [ROW_W-1:0]    h, row0, row_s;
  logic [PAIR_W-1:0]   pair_s;
  logic [1:0]          v;
  logic                a_last, a_adv, accept, empty, live, close, top_row;
  logic [RB_AW-1:0]    dx;
  gbb_tok_t            tok_c;

  always_comb begin
    if ({1'b0, cfg.glyph_width} > 9'(MAX_GLYPH_WIDTH)) begin
      w = COL_W'(MAX_GLYPH_WIDTH);
    end else begin
      w = COL_W'(cfg.glyph_width);
    end
    if ({1'b0, cfg.glyph_height} > 9'(MAX_GLYPH_HEIGHT)) begin
      h = ROW_W'(MAX_GLYPH_HEIGHT);
    end else begin
      h = ROW_W'(cfg.glyph_height);
    end
  end

  assign v      = cfg.two_bit_mode ? byte_r[7:6] : {1'b0, byte_r[7]};
  assign a_last = cfg.two_bit_mode ? (idx_r == PIX_LAST_2B) : (idx_r == PIX_LAST_1B);
  assign a_adv  = a_v_r && (!b_v_r || tok_ready);
  assign in_word.ready = !a_v_r || (a_adv && a_last);
  assign accept = in_word.valid && in_word.ready;

  // wrap the column, then place the pixel
  always_comb begin
    empty = (w == '0) || (h == '0);
    if (col_r >= w) begin
      col0 = '0;
      row0 = (row_r < h) ? ROW_W'(row_r + 1'b1) : row_r;
    end else begin
      col0 = col_r;
      row0 = row_r;
    end
    live    = !empty && (row0 < h);
    col_inc = COL_W'(col0 + 1'b1);
    dx      = col0[RB_AW:1];
    close   = col0[0] || (col0 == COL_W'(w - 1'b1));
    top_row = !row0[0] && (row0 != ROW_W'(h - 1'b1));

    if (empty) begin
      col_s = col_r;
      row_s = row_r;
    end else if (!live) begin
      col_s = col0;
      row_s = row0;
    end else if (col_inc >= w) begin
      col_s = '0;
      row_s = ROW_W'(row0 + 1'b1);
    end else begin
      col_s = col_inc;
      row_s = row0;
    end

    pair_s = pair_r;
    if (live && cfg.half_scale) begin
      if (col0[0]) begin
        pair_s = PAIR_W'(pair_r + PAIR_W'(v));
      end else begin
        pair_s = PAIR_W'(v);
      end
    end

    tok_c.eob     = a_last;
    tok_c.ink     = live && !cfg.half_scale &&
                    (cfg.two_bit_mode ? (v >= cfg.ink_threshold) : v[0]);
    tok_c.sum_chk = live && cfg.half_scale && close && !top_row;
    tok_c.add_row = row0[0];
    tok_c.pair    = pair_s;
    if (cfg.half_scale) begin
      tok_c.x = cfg.origin_x + COORD_W'(dx);
      tok_c.y = cfg.origin_y + COORD_W'(row0 >> 1);
    end else begin
      tok_c.x = cfg.origin_x + COORD_W'(col0);
      tok_c.y = cfg.origin_y + COORD_W'(row0);
    end
  end

  assign rb_we    = a_adv && live && cfg.half_scale && close && top_row;
  assign rb_waddr = dx;
  assign rb_wdata = pair_s;
  assign rb_re    = a_adv;
  assign rb_raddr = dx;

  always_comb begin
    a_v_nxt   = a_v_r;
    byte_nxt  = byte_r;
    idx_nxt   = idx_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    pair_nxt  = pair_r;
    b_v_nxt   = b_v_r;
    b_tok_nxt = b_tok_r;
    if (a_adv) begin
      byte_nxt  = cfg.two_bit_mode ? {byte_r[5:0], 2'b00} : {byte_r[6:0], 1'b0};
      idx_nxt   = 3'(idx_r + 1'b1);
      col_nxt   = col_s;
      row_nxt   = row_s;
      pair_nxt  = pair_s;
      b_tok_nxt = tok_c;
      b_v_nxt   = 1'b1;
      if (a_last) begin
        a_v_nxt = 1'b0;
      end
    end else if (tok_ready) begin
      b_v_nxt = 1'b0;
    end
    if (accept) begin
      a_v_nxt  = 1'b1;
      byte_nxt = in_word.bitmap_byte;
      idx_nxt  = '0;
      if (in_word.first_byte) begin
        col_nxt  = '0;
        row_nxt  = '0;
        pair_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      idx_r  <= '0;
      col_r  <= '0;
      row_r  <= '0;
      pair_r <= '0;
      b_v_r  <= 1'b0;
    end else begin
      a_v_r  <= a_v_nxt;
      idx_r  <= idx_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pair_r <= pair_nxt;
      b_v_r  <= b_v_nxt;
    end
    byte_r  <= byte_nxt;
    b_tok_r <= b_tok_nxt;
  end

  assign tok_valid = b_v_r;
  assign tok       = b_tok_r;

endmodule

`default_nettype wire

### design/gbb_emit.sv
// ----------------------------------------------------------------------------
// gbb_emit
// Ink decision, one-deep hold for end-of-byte marking, and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbb_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        two_bit,
  input  logic                        tok_valid,
  input  gbb_pkg::gbb_tok_t           tok,
  input  logic [gbb_pkg::PAIR_W-1:0]  rb_rdata,
  output logic                        tok_ready,
  gbb_out_if.source                   out_word
);
  import gbb_pkg::*;

  logic                      p_v_r, p_v_nxt;
  logic                      p_fin_r, p_fin_nxt;
  logic signed [COORD_W-1:0] p_x_r, p_x_nxt, p_y_r, p_y_nxt;
  logic                      o_v_r, o_v_nxt;
  logic                      o_last_r, o_last_nxt;
  logic signed [COORD_W-1:0] o_x_r, o_x_nxt, o_y_r, o_y_nxt;

  logic [PAIR_W:0] total;
  logic            ink, o_free, drain, take;

  assign total  = {1'b0, tok.pair} + (tok.add_row ? {1'b0, rb_rdata} : '0);
  assign ink    = tok.ink ||
                  (tok.sum_chk && (two_bit ? (total >= SUM_INK_2B) : (total != '0)));
  assign o_free = !o_v_r || out_word.ready;
  assign drain  = p_v_r && p_fin_r && o_free;
  assign tok_ready = !(p_v_r && p_fin_r) && !(ink && p_v_r && !o_free);
  assign take   = tok_valid && tok_ready;

  always_comb begin
    p_v_nxt    = p_v_r;
    p_fin_nxt  = p_fin_r;
    p_x_nxt    = p_x_r;
    p_y_nxt    = p_y_r;
    o_v_nxt    = o_v_r && !out_word.ready;
    o_last_nxt = o_last_r;
    o_x_nxt    = o_x_r;
    o_y_nxt    = o_y_r;
    if (drain) begin
      // release the held word as the final one of its byte
      o_v_nxt    = 1'b1;
      o_last_nxt = 1'b1;
      o_x_nxt    = p_x_r;
      o_y_nxt    = p_y_r;
      p_v_nxt    = 1'b0;
      p_fin_nxt  = 1'b0;
    end else if (take) begin
      if (ink) begin
        if (p_v_r) begin
          o_v_nxt    = 1'b1;
          o_last_nxt = 1'b0;
          o_x_nxt    = p_x_r;
          o_y_nxt    = p_y_r;
        end
        p_v_nxt   = 1'b1;
        p_fin_nxt = tok.eob;
        p_x_nxt   = tok.x;
        p_y_nxt   = tok.y;
      end else if (tok.eob && p_v_r) begin
        p_fin_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r   <= 1'b0;
      p_fin_r <= 1'b0;
      o_v_r   <= 1'b0;
    end else begin
      p_v_r   <= p_v_nxt;
      p_fin_r <= p_fin_nxt;
      o_v_r   <= o_v_nxt;
    end
    p_x_r    <= p_x_nxt;
    p_y_r    <= p_y_nxt;
    o_last_r <= o_last_nxt;
    o_x_r    <= o_x_nxt;
    o_y_r    <= o_y_nxt;
  end

  assign out_word.valid       = o_v_r;
  assign out_word.pixel_x     = o_x_r;
  assign out_word.pixel_y     = o_y_r;
  assign out_word.last_of_run = o_last_r;

endmodule

`default_nettype wire

### design/glyph_bitmap_blitter.sv
// ----------------------------------------------------------------------------
// glyph_bitmap_blitter
// Packed glyph bitmap to ink pixel stream, full size or 2x2 downscaled.
//
//   channel   direction  handshake     payload
//   in_word   sink       valid/ready   bitmap_byte, first_byte
//   out_word  source     valid/ready   pixel_x, pixel_y, last_of_run
//   cfg_*     sink       cfg_we        cfg_index, cfg_wdata
//
// One source pixel a cycle unless stalled; 8 a byte in 1-bit mode, 4 in 2-bit.
// The row buffer RAM is read each pixel and written at half-scale top-row
// pair closes, with registered reads. An inked byte stalls for its final word.
// Synchronous active-low reset clears control state; the row buffer is not
// cleared. A stalled out_word holds the pipeline back to in_word.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_bitmap_blitter (
  input  logic                               clk,
  input  logic                               rst_n,
  gbb_in_if.sink                             in_word,
  gbb_out_if.source                          out_word,
  input  logic                               cfg_we,
  input  logic [gbb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gbb_pkg::*;

  gbb_cfg_t          cfg_r, cfg_nxt;
  logic              tok_valid, tok_ready;
  gbb_tok_t          tok;
  logic              rb_we, rb_re;
  logic [RB_AW-1:0]  rb_waddr, rb_raddr;
  logic [PAIR_W-1:0] rb_wdata, rb_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:      cfg_nxt.origin_x      = cfg_wdata;
        CFG_ORIGIN_Y:      cfg_nxt.origin_y      = cfg_wdata;
        CFG_GLYPH_WIDTH:   cfg_nxt.glyph_width   = cfg_wdata[7:0];
        CFG_GLYPH_HEIGHT:  cfg_nxt.glyph_height  = cfg_wdata[7:0];
        CFG_TWO_BIT_MODE:  cfg_nxt.two_bit_mode  = cfg_wdata[0];
        CFG_HALF_SCALE:    cfg_nxt.half_scale    = cfg_wdata[0];
        CFG_INK_THRESHOLD: cfg_nxt.ink_threshold = cfg_wdata[1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{origin_x:      '0,
                 origin_y:      '0,
                 glyph_width:   '0,
                 glyph_height:  '0,
                 two_bit_mode:  1'b0,
                 half_scale:    1'b0,
                 ink_threshold: THRESH_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gbb_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_word   (in_word),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_ready (tok_ready),
    .rb_we     (rb_we),
    .rb_waddr  (rb_waddr),
    .rb_wdata  (rb_wdata),
    .rb_re     (rb_re),
    .rb_raddr  (rb_raddr)
  );

  gbb_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (ROWBUF_DEPTH)
  ) u_rowbuf (
    .clk   (clk),
    .we    (rb_we),
    .waddr (rb_waddr),
    .wdata (rb_wdata),
    .re    (rb_re),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  gbb_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .two_bit   (cfg_r.two_bit_mode),
    .tok_valid (tok_valid),
    .tok       (tok),
    .rb_rdata  (rb_rdata),
    .tok_ready (tok_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
